// ===== design/assert_macros.svh =====
// assertion macros shared by the rtl
// no dependencies; included by files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// condition must never be seen out of reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== design/bte_pkg.sv =====
// types and constants for the bcd timestamp to epoch converter
// no dependencies; imported by every module of the block
package bte_pkg;

  // reset value of the century pivot register
  localparam logic [6:0] PivotReset = 7'd94;
  // two-digit years below the pivot land one century later
  localparam logic [8:0] CenturyStep = 9'd100;
  // years after 1900 past which 2100 (not a leap year) is included
  localparam logic [8:0] Yr2100Off = 9'd200;
  // days from 1900-01-01 to 1970-01-01, plus one for day-of-year base 1
  localparam logic signed [17:0] EpochDayBias = 18'sd25568;
  localparam logic signed [35:0] SecsPerDay = 36'sd86400;
  localparam logic [16:0] DaysPerYear = 17'd365;

  // one input timestamp, seven packed bcd bytes
  typedef struct packed {
    logic [7:0] year_byte;
    logic [7:0] day_high_byte;
    logic [7:0] day_hour_byte;
    logic [7:0] hour_minute_byte;
    logic [7:0] minute_second_byte;
    logic [7:0] second_milli_byte;
    logic [7:0] milli_tens_byte;
  } stamp_t;

  // one result
  typedef struct packed {
    logic [32:0] epoch_seconds;
    logic [10:0] milliseconds;
  } result_t;

  // decoded item between front and back
  typedef struct packed {
    logic signed [17:0] days;
    logic [19:0]        tod;
    logic [10:0]        ms;
  } work_t;

  // push side of the queue
  typedef struct packed {
    logic  valid;
    work_t work;
  } q_push_t;

  // queue status seen by the front
  typedef struct packed {
    logic       full;
    logic [1:0] count;
  } q_stat_t;

endpackage

// ===== design/bte_front.sv =====
// front end: accepts timestamps, decodes bcd digits into day count and time of day
// depends on bte_pkg
module bte_front import bte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  stamp_t     stamp,
  input  logic [6:0] pivot,
  input  q_stat_t    q_stat,
  output logic       busy,
  output q_push_t    push
);

  logic       valid;
  work_t      work;
  logic       take;
  logic       ready;
  work_t      dec;

  logic [7:0]  yr;
  logic [8:0]  yo;
  logic [6:0]  leaps;
  logic [16:0] d1900;
  logic [10:0] day;
  logic [7:0]  hour;
  logic [7:0]  minute;
  logic [7:0]  second;

  // holding register drains into the queue whenever it has room
  assign push.valid = valid;
  assign push.work  = work;
  assign ready      = !valid || !q_stat.full;
  assign busy       = !ready;
  assign take       = start && ready;

  // digit decode
  always_comb begin
    yr     = 8'({4'b0, stamp.year_byte[7:4]} * 8'd10) + {4'b0, stamp.year_byte[3:0]};
    yo     = ({1'b0, yr} < {2'b0, pivot}) ? ({1'b0, yr} + CenturyStep) : {1'b0, yr};
    day    = 11'({7'b0, stamp.day_high_byte[7:4]} * 11'd100)
           + 11'({7'b0, stamp.day_high_byte[3:0]} * 11'd10)
           + {7'b0, stamp.day_hour_byte[7:4]};
    hour   = 8'({4'b0, stamp.day_hour_byte[3:0]} * 8'd10) + {4'b0, stamp.hour_minute_byte[7:4]};
    minute = 8'({4'b0, stamp.hour_minute_byte[3:0]} * 8'd10)
           + {4'b0, stamp.minute_second_byte[7:4]};
    second = 8'({4'b0, stamp.minute_second_byte[3:0]} * 8'd10)
           + {4'b0, stamp.second_milli_byte[7:4]};
  end

  // days from 1900 to jan 1 of the year: multiples of four, minus 1900 and 2100
  always_comb begin
    leaps = 7'((yo + 9'd3) >> 2) - 7'(yo != 9'd0) - 7'(yo > Yr2100Off);
    d1900 = 17'({8'b0, yo} * DaysPerYear) + {10'b0, leaps};
    dec.days = $signed({1'b0, d1900}) + $signed({7'b0, day}) - EpochDayBias;
    dec.tod  = 20'({12'b0, hour} * 20'd3600) + 20'({12'b0, minute} * 20'd60)
             + {12'b0, second};
    dec.ms   = 11'({7'b0, stamp.second_milli_byte[3:0]} * 11'd100)
             + 11'({7'b0, stamp.milli_tens_byte[7:4]} * 11'd10);
  end

  // holding register control
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (!q_stat.full) begin
      valid <= 1'b0;
    end
  end

  // holding register payload
  always_ff @(posedge clk) begin
    if (take) begin
      work <= dec;
    end
  end

endmodule

// ===== design/bte_queue.sv =====
// two-entry queue between the front and back ends
// depends on bte_pkg
module bte_queue import bte_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  q_push_t push,
  input  logic    pop,
  output q_stat_t stat,
  output logic    not_empty,
  output work_t   head
);

  work_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign stat.full  = (count == 2'd2);
  assign stat.count = count;
  assign not_empty  = (count != 2'd0);
  assign head       = mem[rd_ptr];
  assign do_push    = push.valid && !stat.full;
  assign do_pop     = pop && not_empty;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.work;
    end
  end

endmodule

// ===== design/bte_back.sv =====
// back end: scales the day count to seconds, adds time of day, clamps at zero
// depends on bte_pkg
module bte_back import bte_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    not_empty,
  input  work_t   head,
  output logic    pop,
  output logic    done,
  output result_t result
);

  logic               s1_valid;
  logic signed [35:0] s1_prod;
  logic [19:0]        s1_tod;
  logic [10:0]        s1_ms;
  logic signed [35:0] sum;

  // never stalls: take the head whenever there is one
  assign pop = not_empty;

  // stage one valid and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= not_empty;
      done     <= s1_valid;
    end
  end

  // stage one: day count times seconds per day
  always_ff @(posedge clk) begin
    if (not_empty) begin
      s1_prod <= 36'(head.days) * SecsPerDay;
      s1_tod  <= head.tod;
      s1_ms   <= head.ms;
    end
  end

  // stage two: add time of day, clamp instants before 1970
  assign sum = s1_prod + $signed({16'b0, s1_tod});

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      result.epoch_seconds <= sum[35] ? 33'd0 : sum[32:0];
      result.milliseconds  <= s1_ms;
    end
  end

endmodule

// ===== design/bcd_timestamp_to_epoch.sv =====
// top level of the bcd day-of-year timestamp to unix time converter
// depends on bte_pkg, bte_front, bte_queue, bte_back and assert_macros.svh
`include "assert_macros.svh"

// Takes one timestamp per clock while busy is low and gives one result per
// timestamp, strobed by done for a single cycle, once it has passed the
// holding register, the queue, the multiply stage and the output register.
// The result path has no back-pressure: the back end drains the
// queue every cycle, so busy only rises if the queue fills, which it does not
// in steady state. The day count times 86400 multiplier sets the pace at one
// item per clock. Writes to the pivot register are taken at any time
// (cfg_ready is always high) and apply to items accepted afterwards.
module bcd_timestamp_to_epoch import bte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  stamp_t     stamp,
  output logic       busy,
  output logic       done,
  output result_t    result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  logic [6:0] pivot;
  q_push_t    push;
  q_stat_t    q_stat;
  logic       not_empty;
  logic       pop;
  work_t      head;

  assign cfg_ready = 1'b1;

  // century pivot register
  always_ff @(posedge clk) begin
    if (rst) begin
      pivot <= PivotReset;
    end else if (cfg_valid && cfg_ready) begin
      pivot <= cfg_data;
    end
  end

  bte_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .stamp  (stamp),
    .pivot  (pivot),
    .q_stat (q_stat),
    .busy   (busy),
    .push   (push)
  );

  bte_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .stat      (q_stat),
    .not_empty (not_empty),
    .head      (head)
  );

  bte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .done      (done),
    .result    (result)
  );

  // checks
  `ASSERT_NEVER(a_queue_overfill, clk, rst, q_stat.count == 2'd3)
  `ASSERT_IMPLIES(a_busy_means_held, clk, rst, busy, push.valid && q_stat.full)
  `ASSERT_IMPLIES(a_ms_range, clk, rst, done, result.milliseconds <= 11'd1650)
  `ASSERT_IMPLIES(a_pop_when_filled, clk, rst, q_stat.count != 2'd0, pop)

endmodule

// ===== tb/bte_checker.sv =====
// checker for the bcd timestamp to epoch converter: watches the item, result
// and pivot channels, predicts each result and compares it field by field
// depends on bte_pkg
module bte_checker import bte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  stamp_t     stamp,
  input  logic       done,
  input  result_t    result,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [6:0] cfg_data,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxReports = 10;

  logic [6:0] pivot_shadow;
  result_t    expected_results[$];
  int         fail_count = 0;

  // gregorian leap years in [1, y)
  function automatic longint leap_years_before(longint y);
    longint p;
    p = y - 1;
    return p / 4 - p / 100 + p / 400;
  endfunction

  // utc seconds and milliseconds of one timestamp under a given pivot
  function automatic result_t predict_epoch(stamp_t s, logic [6:0] piv);
    longint  yr, day, hr, mn, sc, full_year, day_count, secs;
    result_t r;
    yr  = longint'(s.year_byte[7:4]) * 10 + longint'(s.year_byte[3:0]);
    day = longint'(s.day_high_byte[7:4]) * 100 + longint'(s.day_high_byte[3:0]) * 10
          + longint'(s.day_hour_byte[7:4]);
    hr  = longint'(s.day_hour_byte[3:0]) * 10 + longint'(s.hour_minute_byte[7:4]);
    mn  = longint'(s.hour_minute_byte[3:0]) * 10 + longint'(s.minute_second_byte[7:4]);
    sc  = longint'(s.minute_second_byte[3:0]) * 10 + longint'(s.second_milli_byte[7:4]);
    // years under the pivot move up one century
    if (yr < longint'(piv)) begin
      yr = yr + 100;
    end
    full_year = yr + 1900;
    day_count = 365 * (full_year - 1970) + leap_years_before(full_year)
                - leap_years_before(1970) + day - 1;
    secs = day_count * 86400 + hr * 3600 + mn * 60 + sc;
    // instants before 1970 clamp to zero
    if (secs < 0) begin
      secs = 0;
    end
    r.epoch_seconds = secs[32:0];
    r.milliseconds  = 11'(s.second_milli_byte[3:0] * 100 + s.milli_tens_byte[7:4] * 10);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      pivot_shadow = PivotReset;
      expected_results.delete();
    end else begin
      // compare a strobed result with the oldest expectation
      if (done) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display("%0t: result with none expected: secs %0d ms %0d",
                     $realtime, result.epoch_seconds, result.milliseconds);
          end
        end else begin
          want = expected_results.pop_front();
          if (result.epoch_seconds !== want.epoch_seconds ||
              result.milliseconds !== want.milliseconds) begin
            fail_count++;
            if (fail_count <= MaxReports) begin
              $display("%0t: mismatch: secs exp %0d got %0d, ms exp %0d got %0d",
                       $realtime, want.epoch_seconds, result.epoch_seconds,
                       want.milliseconds, result.milliseconds);
            end
          end
        end
      end
      // accepted item, predicted with the pivot in force before this edge
      if (start && !busy) begin
        expected_results.push_back(predict_epoch(stamp, pivot_shadow));
      end
      // pivot write
      if (cfg_valid && cfg_ready) begin
        pivot_shadow = cfg_data;
      end
    end
    errors  <= fail_count;
    pending <= expected_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// testbench top for the bcd timestamp to epoch converter: clock, reset,
// timestamp stimulus, pivot writes, watchdog and verdict
// depends on bte_pkg, bcd_timestamp_to_epoch and bte_checker
module tb_top import bte_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit   = 200;
  localparam int ItemsPerSet = 190;
  localparam int NumSets     = 8;

  logic       clk;
  logic       rst;
  logic       start;
  stamp_t     stamp_in;
  logic       busy;
  logic       done;
  result_t    result;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [6:0] cfg_data;
  int         errors;
  int         pending;
  int         idle_cycles;
  int         burst_left;

  bcd_timestamp_to_epoch DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .stamp     (stamp_in),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  bte_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .stamp     (stamp_in),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // pack decimal fields into bcd bytes, junk in the ignored nibble
  function automatic stamp_t build_stamp(int yr, int day, int hr, int mn, int sc,
                                         int ms_h, int ms_t);
    stamp_t s;
    s.year_byte          = 8'((yr / 10 % 10) * 16 + yr % 10);
    s.day_high_byte      = 8'((day / 100 % 10) * 16 + day / 10 % 10);
    s.day_hour_byte      = 8'((day % 10) * 16 + hr / 10 % 10);
    s.hour_minute_byte   = 8'((hr % 10) * 16 + mn / 10 % 10);
    s.minute_second_byte = 8'((mn % 10) * 16 + sc / 10 % 10);
    s.second_milli_byte  = 8'((sc % 10) * 16 + ms_h % 10);
    s.milli_tens_byte    = 8'((ms_t % 10) * 16 + $urandom_range(0, 15));
    return s;
  endfunction

  function automatic stamp_t raw_stamp(logic [7:0] b);
    stamp_t s;
    s = {7{b}};
    return s;
  endfunction

  // mostly sane timestamps, some out of range, some raw noise
  function automatic stamp_t random_stamp();
    stamp_t s;
    int     pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      s = build_stamp($urandom_range(0, 99), $urandom_range(1, 366), $urandom_range(0, 23),
                      $urandom_range(0, 59), $urandom_range(0, 60), $urandom_range(0, 9),
                      $urandom_range(0, 9));
    end else if (pick < 8) begin
      s = build_stamp($urandom_range(0, 99), $urandom_range(0, 999), $urandom_range(0, 99),
                      $urandom_range(0, 99), $urandom_range(0, 99), $urandom_range(0, 9),
                      $urandom_range(0, 9));
    end else begin
      s.year_byte          = 8'($urandom);
      s.day_high_byte      = 8'($urandom);
      s.day_hour_byte      = 8'($urandom);
      s.hour_minute_byte   = 8'($urandom);
      s.minute_second_byte = 8'($urandom);
      s.second_milli_byte  = 8'($urandom);
      s.milli_tens_byte    = 8'($urandom);
    end
    return s;
  endfunction

  // offer one item after a random gap, return at the edge that takes it
  task automatic send_stamp(stamp_t s);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(10, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 11);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    stamp_in <= s;
    do @(posedge clk); while (busy);
  endtask

  // hold off until every expected result is back, then idle a little longer
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_pivot(logic [6:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [6:0] set_pivot [NumSets];
    rst        = 1'b1;
    start      = 1'b0;
    stamp_in   = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed items under the reset pivot
    send_stamp(raw_stamp(8'h00));                    // day zero of 2000
    send_stamp(raw_stamp(8'hFF));                    // every nibble fifteen
    send_stamp(raw_stamp(8'hAA));
    send_stamp(raw_stamp(8'h55));
    send_stamp(build_stamp(93, 1, 0, 0, 0, 0, 0));   // just under the pivot
    send_stamp(build_stamp(94, 1, 0, 0, 0, 0, 0));   // at the pivot
    send_stamp(build_stamp(99, 365, 23, 59, 59, 9, 9));
    send_stamp(build_stamp(0, 60, 12, 0, 0, 5, 0));  // leap day
    send_stamp(build_stamp(96, 366, 23, 59, 59, 0, 0));
    send_stamp(build_stamp(97, 366, 0, 0, 0, 0, 0)); // day past year end
    send_stamp(build_stamp(1, 0, 0, 0, 0, 0, 0));    // day zero after leap year
    send_stamp(build_stamp(0, 999, 99, 99, 99, 9, 9));
    send_stamp(build_stamp(50, 59, 24, 60, 60, 0, 9));

    // pivot zero: all years in the 1900s, some before 1970
    write_pivot(7'd0);
    send_stamp(build_stamp(70, 1, 0, 0, 0, 0, 0));   // epoch itself
    send_stamp(build_stamp(69, 365, 23, 59, 59, 0, 0));
    send_stamp(build_stamp(0, 1, 0, 0, 0, 0, 0));
    send_stamp(build_stamp(69, 366, 0, 0, 0, 0, 0));
    send_stamp(build_stamp(69, 365, 24, 0, 0, 0, 0));

    // largest raw pivot: the biggest instants
    write_pivot(7'd127);
    send_stamp(build_stamp(99, 1, 0, 0, 0, 0, 0));
    send_stamp(raw_stamp(8'hFF));
    send_stamp(raw_stamp(8'hC6));

    // random sets under several pivots
    set_pivot[0] = 7'd99;
    set_pivot[1] = 7'($urandom_range(0, 127));
    set_pivot[2] = 7'd1;
    set_pivot[3] = 7'd0;
    set_pivot[4] = 7'($urandom_range(0, 99));
    set_pivot[5] = 7'd127;
    set_pivot[6] = 7'd70;
    set_pivot[7] = PivotReset;
    for (int k = 0; k < NumSets; k++) begin
      write_pivot(set_pivot[k]);
      for (int n = 0; n < ItemsPerSet; n++) begin
        send_stamp(random_stamp());
        // occasionally wait for the pipeline to empty mid set
        if ($urandom_range(0, 99) == 0) begin
          drain();
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
